// ===== rtl/core/fsps_pkg.sv =====
// ----------------------------------------------------------------------------
// fsps_pkg
// Shared types and constants for the flow sweep pressure setpoint block.
// ----------------------------------------------------------------------------
package fsps_pkg;

    // Field widths
    localparam int TIME_W     = 32;
    localparam int FLOW_W     = 32;
    localparam int RATE_W     = 16;
    localparam int DSP_W      = 16;
    localparam int DAC_W      = 12;
    localparam int SPO_W      = 27;
    localparam int CYC_W      = 16;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int FRAC_W     = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_DIRECT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLOW   = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FLOW_LO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLOW_HI = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE    = 2'd2;

    // Step arithmetic: rate is Q8.8, so rate*e needs 8 more fraction bits
    localparam int STEP_DIV   = 1000;
    localparam int DOWN_SHIFT = 8;

    // Shared multiplier
    localparam int MUL_W = 32;

    // Shared divider: 64-bit dividend, 16-bit divisor, 4 quotient bits per cycle
    localparam int DIV_W     = 64;
    localparam int DVS_W     = 16;
    localparam int DIV_STEP  = 4;
    localparam int DIV_ITER  = DIV_W / DIV_STEP;
    localparam int DIV_CNT_W = $clog2(DIV_ITER);

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== rtl/core/fsps_mul.sv =====
// ----------------------------------------------------------------------------
// fsps_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module fsps_mul
    import fsps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [MUL_W-1:0]   i_a,
    input  logic [MUL_W-1:0]   i_b,
    output logic [2*MUL_W-1:0] o_p
);

    logic [2*MUL_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= (2*MUL_W)'(i_a) * (2*MUL_W)'(i_b);
        end
    end

    assign o_p = r_p;

endmodule

// ===== rtl/core/fsps_div.sv =====
// ----------------------------------------------------------------------------
// fsps_div
// Iterative restoring divider, DIV_STEP quotient bits per cycle.
// ----------------------------------------------------------------------------
module fsps_div
    import fsps_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIV_W-1:0]     r_quo;
    logic [DVS_W-1:0]     r_rem;
    logic [DVS_W-1:0]     r_dvs;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_W-1:0]     n_quo;
    logic [DVS_W-1:0]     n_rem;

    // Dividend bits shift out of the top of r_quo while quotient bits enter below
    always_comb begin
        logic [DVS_W:0] t;
        n_quo = r_quo;
        n_rem = r_rem;
        for (int k = 0; k < DIV_STEP; k++) begin
            t     = {n_rem, n_quo[DIV_W-1]};
            n_quo = {n_quo[DIV_W-2:0], 1'b0};
            if (t >= {1'b0, r_dvs}) begin
                n_rem    = DVS_W'(t - {1'b0, r_dvs});
                n_quo[0] = 1'b1;
            end else begin
                n_rem = t[DVS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_ITER - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== rtl/core/flow_sweep_pressure_setpoint.sv =====
// ----------------------------------------------------------------------------
// flow_sweep_pressure_setpoint
// Sweeps a Q11.16 pressure setpoint against measured flow, drives a DAC code.
// A direct set runs one multiply and one divide for the DAC code; a sweep step first
//   runs one (down) or two (up) passes through the shared multiplier and a step divide.
// Start, unarmed flow, flow on a limit and unused codes produce no result.
// Throughput: one item at a time; the next is taken once the result is loaded.
// Reset (synchronous, active low) clears setpoint, timestamp, arm, direction,
//   cycle count and loads the default limits and a zero rate.
// ----------------------------------------------------------------------------
module flow_sweep_pressure_setpoint
    import fsps_pkg::*;
#(
    parameter int FULL_SCALE = 1024,
    parameter int DAC_MAX    = 4095
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic        [CMD_W-1:0]     i_command,
    input  logic        [TIME_W-1:0]    i_time_ms,
    input  logic signed [DSP_W-1:0]     i_direct_setpoint,
    input  logic signed [FLOW_W-1:0]    i_flow_sample,

    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic        [DAC_W-1:0]     o_dac_code,
    output logic        [SPO_W-1:0]     o_setpoint_out,
    output logic                        o_going_down,
    output logic        [CYC_W-1:0]     o_cycle_count_out,

    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic        [CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SP_W = $clog2(FULL_SCALE + 1) + FRAC_W;
    localparam logic [SP_W-1:0]  SP_TOP = SP_W'(64'(FULL_SCALE) << FRAC_W);
    localparam logic [DSP_W-1:0] FS_INT = DSP_W'(FULL_SCALE);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_DIV_STEP,
        ST_WAIT_STEP,
        ST_DAC_MUL,
        ST_DAC_DIV,
        ST_WAIT_DAC,
        ST_FINISH
    } t_state;

    // Configuration
    logic signed [FLOW_W-1:0] r_flow_lo;
    logic signed [FLOW_W-1:0] r_flow_hi;
    logic        [RATE_W-1:0] r_rate;

    // Sweep state
    t_state             r_state;
    logic [SP_W-1:0]    r_setpoint;
    logic [TIME_W-1:0]  r_last_time;
    logic               r_armed;
    logic               r_dir_down;
    logic [CYC_W-1:0]   r_cycle_count;

    // Per-item working registers
    logic [TIME_W-1:0]  r_elapsed;
    logic               r_step_down;
    logic [CYC_W-1:0]   r_cnt_out;
    logic [DAC_W-1:0]   r_dac;

    // Output register
    logic               r_out_valid;
    logic [DAC_W-1:0]   r_out_dac;
    logic [SPO_W-1:0]   r_out_sp;
    logic               r_out_down;
    logic [CYC_W-1:0]   r_out_cnt;

    logic [MUL_W-1:0]   w_mul_a;
    logic [MUL_W-1:0]   w_mul_b;
    logic               w_mul_en;
    logic [2*MUL_W-1:0] w_prod;
    t_div_req           w_div_req;
    t_div_rsp           w_div_rsp;

    logic               w_accept;
    logic               w_out_free;
    logic               w_lt_lo;
    logic               w_gt_hi;
    logic               w_lt_hi;
    logic               w_gt_lo;
    logic [TIME_W-1:0]  n_elapsed;
    logic [DSP_W-1:0]   w_dir_clamp;
    logic [SP_W-1:0]    n_sp_direct;
    logic [SP_W-1:0]    w_room;
    logic [SP_W-1:0]    n_sp_step;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow_lo <= 32'sd65536;
            r_flow_hi <= 32'sd655360;
            r_rate    <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FLOW_LO: r_flow_lo <= $signed(i_cfg_data);
                REG_FLOW_HI: r_flow_hi <= $signed(i_cfg_data);
                REG_RATE:    r_rate    <= i_cfg_data[RATE_W-1:0];
                default:     ;
            endcase
        end
    end

    // ---------------- shared units ----------------
    always_comb begin
        w_mul_a  = '0;
        w_mul_b  = '0;
        w_mul_en = 1'b1;
        unique case (r_state)
            ST_MUL_A: begin
                // down: rate*e; up: rate*rate
                w_mul_a = MUL_W'(r_rate);
                w_mul_b = r_step_down ? MUL_W'(r_elapsed) : MUL_W'(r_rate);
            end
            ST_MUL_B: begin
                w_mul_a = w_prod[MUL_W-1:0];
                w_mul_b = MUL_W'(r_elapsed);
            end
            ST_DAC_MUL: begin
                w_mul_a = MUL_W'(r_setpoint);
                w_mul_b = MUL_W'(DAC_MAX);
            end
            default: w_mul_en = 1'b0;
        endcase
    end

    fsps_mul u_mul (
        .i_clk (i_clk),
        .i_en  (w_mul_en),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    // DAC code = floor(floor(sp*DAC_MAX / 2^16) / FULL_SCALE)
    always_comb begin
        w_div_req.start = (r_state == ST_DIV_STEP) || (r_state == ST_DAC_DIV);
        if (r_state == ST_DAC_DIV) begin
            w_div_req.dividend = DIV_W'(w_prod[2*MUL_W-1:FRAC_W]);
            w_div_req.divisor  = DVS_W'(FULL_SCALE);
        end else begin
            w_div_req.dividend = r_step_down ? (w_prod << DOWN_SHIFT) : w_prod;
            w_div_req.divisor  = DVS_W'(STEP_DIV);
        end
    end

    fsps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // ---------------- decode at accept ----------------
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_lt_lo = i_flow_sample < r_flow_lo;
    assign w_gt_hi = i_flow_sample > r_flow_hi;
    assign w_lt_hi = i_flow_sample < r_flow_hi;
    assign w_gt_lo = i_flow_sample > r_flow_lo;

    assign n_elapsed = (i_time_ms >= r_last_time) ? (i_time_ms - r_last_time)
                                                  : (r_last_time - i_time_ms);

    always_comb begin
        if (i_direct_setpoint[DSP_W-1]) begin
            w_dir_clamp = '0;
        end else if (DSP_W'(i_direct_setpoint) > FS_INT) begin
            w_dir_clamp = FS_INT;
        end else begin
            w_dir_clamp = DSP_W'(i_direct_setpoint);
        end
    end

    assign n_sp_direct = SP_W'({w_dir_clamp, {FRAC_W{1'b0}}});

    // Saturating step on the quotient
    assign w_room = SP_TOP - r_setpoint;

    always_comb begin
        if (r_step_down) begin
            n_sp_step = (w_div_rsp.quotient >= DIV_W'(r_setpoint))
                      ? '0 : (r_setpoint - w_div_rsp.quotient[SP_W-1:0]);
        end else begin
            n_sp_step = (w_div_rsp.quotient >= DIV_W'(w_room))
                      ? SP_TOP : (r_setpoint + w_div_rsp.quotient[SP_W-1:0]);
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_setpoint    <= '0;
            r_last_time   <= '0;
            r_armed       <= 1'b0;
            r_dir_down    <= 1'b0;
            r_cycle_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            // ST_FINISH reloads the output register on its own
            if (r_out_valid && !i_out_stall && (r_state != ST_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_elapsed <= n_elapsed;
                        r_cnt_out <= r_cycle_count;
                        case (i_command)
                            CMD_DIRECT: begin
                                r_setpoint  <= n_sp_direct;
                                r_step_down <= 1'b0;
                                r_state     <= ST_DAC_MUL;
                            end
                            CMD_START: begin
                                r_armed     <= 1'b1;
                                r_last_time <= i_time_ms;
                            end
                            CMD_FLOW: begin
                                if (!r_armed) begin
                                    r_armed     <= 1'b1;
                                    r_last_time <= i_time_ms;
                                end else if (w_lt_lo) begin
                                    r_dir_down    <= 1'b0;
                                    r_step_down   <= 1'b0;
                                    r_last_time   <= i_time_ms;
                                    r_cycle_count <= r_cycle_count + 1'b1;
                                    r_state       <= ST_MUL_A;
                                end else if (w_gt_hi) begin
                                    r_dir_down    <= 1'b1;
                                    r_step_down   <= 1'b1;
                                    r_last_time   <= i_time_ms;
                                    r_cycle_count <= r_cycle_count + 1'b1;
                                    r_state       <= ST_MUL_A;
                                end else if (w_lt_hi && w_gt_lo) begin
                                    // keep last direction, no count
                                    r_step_down <= r_dir_down;
                                    r_last_time <= i_time_ms;
                                    r_state     <= ST_MUL_A;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_MUL_A: begin
                    r_state <= r_step_down ? ST_DIV_STEP : ST_MUL_B;
                end
                ST_MUL_B: begin
                    r_state <= ST_DIV_STEP;
                end
                ST_DIV_STEP: begin
                    r_state <= ST_WAIT_STEP;
                end
                ST_WAIT_STEP: begin
                    if (w_div_rsp.done) begin
                        r_setpoint <= n_sp_step;
                        r_state    <= ST_DAC_MUL;
                    end
                end
                ST_DAC_MUL: begin
                    r_state <= ST_DAC_DIV;
                end
                ST_DAC_DIV: begin
                    r_state <= ST_WAIT_DAC;
                end
                ST_WAIT_DAC: begin
                    if (w_div_rsp.done) begin
                        r_dac   <= w_div_rsp.quotient[DAC_W-1:0];
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_dac   <= r_dac;
                        r_out_sp    <= SPO_W'(r_setpoint);
                        r_out_down  <= r_step_down;
                        r_out_cnt   <= r_cnt_out;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_dac_code        = r_out_dac;
    assign o_setpoint_out    = r_out_sp;
    assign o_going_down      = r_out_down;
    assign o_cycle_count_out = r_out_cnt;

endmodule

// ===== rtl/core/fsps_chk.sv =====
// ----------------------------------------------------------------------------
// fsps_chk
// Port-level checks for the flow sweep pressure setpoint block.
// ----------------------------------------------------------------------------
module fsps_chk
    import fsps_pkg::*;
#(
    parameter int FULL_SCALE = 1024
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic [CMD_W-1:0]   i_command,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [DAC_W-1:0]   o_dac_code,
    input logic [SPO_W-1:0]   o_setpoint_out,
    input logic               o_going_down,
    input logic [CYC_W-1:0]   o_cycle_count_out
);

    localparam logic [47:0] TOP_Q16 = 48'(FULL_SCALE) << FRAC_W;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_dac_code)
            && $stable(o_setpoint_out) && $stable(o_going_down)
            && $stable(o_cycle_count_out))
        else $error("result changed while stalled");

    // A direct set keeps the block busy until its result is loaded
    a_direct_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_command == CMD_DIRECT) |=> o_in_stall)
        else $error("direct set did not occupy the sequencer");

    // Start only arms; the block is free again in the next cycle
    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_command == CMD_START) |=> !o_in_stall)
        else $error("start command left the block busy");

    // A new result comes only out of a busy sequencer
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without work in progress");

    // Setpoint never passes full scale
    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (48'(o_setpoint_out) <= TOP_Q16))
        else $error("setpoint above full scale");

endmodule

bind flow_sweep_pressure_setpoint fsps_chk #(
    .FULL_SCALE (FULL_SCALE)
) u_fsps_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .i_command         (i_command),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_dac_code        (o_dac_code),
    .o_setpoint_out    (o_setpoint_out),
    .o_going_down      (o_going_down),
    .o_cycle_count_out (o_cycle_count_out)
);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Regression for flow_sweep_pressure_setpoint: a table of directed commands,
// then random sweep traffic over several limit and rate settings, with random
// gaps on the input side and random stalls on the output side. Every setpoint
// update is checked field by field against the table or a local prediction of the sweep.
// ----------------------------------------------------------------------------
module testbench;
    import fsps_pkg::*;

    localparam int FULL_SCALE    = 1024;
    localparam int DAC_MAX       = 4095;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int SETTLE_CYCLES = 50;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int TAIL_CYCLES   = 60;
    localparam int N_DIRECTED    = 25;
    localparam int N_PHASES      = 6;
    localparam int PHASE_ITEMS   = 250;

    // Code 3 has no meaning in the block; it must be dropped silently
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [DAC_W-1:0] dac;
        logic [SPO_W-1:0] setpoint;
        logic             down;
        logic [CYC_W-1:0] crossings;
    } sweep_result_t;

    typedef struct packed {
        logic                  is_reg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic [CMD_W-1:0]      cmd;
        logic [TIME_W-1:0]     t;
        logic [DSP_W-1:0]      dsp;
        logic [FLOW_W-1:0]     flow;
        logic                  typed;
        sweep_result_t         want;
    } dir_row_t;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic        [CMD_W-1:0]      i_command;
    logic        [TIME_W-1:0]     i_time_ms;
    logic signed [DSP_W-1:0]      i_direct_setpoint;
    logic signed [FLOW_W-1:0]     i_flow_sample;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic        [DAC_W-1:0]      o_dac_code;
    logic        [SPO_W-1:0]      o_setpoint_out;
    logic                         o_going_down;
    logic        [CYC_W-1:0]      o_cycle_count_out;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic        [CFG_IDX_W-1:0]  i_cfg_index;
    logic        [CFG_DATA_W-1:0] i_cfg_data;

    flow_sweep_pressure_setpoint #(
        .FULL_SCALE (FULL_SCALE),
        .DAC_MAX    (DAC_MAX)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_command         (i_command),
        .i_time_ms         (i_time_ms),
        .i_direct_setpoint (i_direct_setpoint),
        .i_flow_sample     (i_flow_sample),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_dac_code        (o_dac_code),
        .o_setpoint_out    (o_setpoint_out),
        .o_going_down      (o_going_down),
        .o_cycle_count_out (o_cycle_count_out),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Predicted sweep state and register copy
    logic        [63:0]       m_setpoint;
    logic        [TIME_W-1:0] m_last_ms;
    logic                     m_armed;
    logic                     m_down;
    logic        [CYC_W-1:0]  m_crossings;
    logic signed [FLOW_W-1:0] m_flow_lo;
    logic signed [FLOW_W-1:0] m_flow_hi;
    logic        [RATE_W-1:0] m_rate;

    sweep_result_t expected_updates[$];
    dir_row_t      directed_tbl [N_DIRECTED];
    int unsigned   cycles;
    int unsigned   mismatches;
    int unsigned   stall_hold;
    int unsigned   stall_roll;
    logic [TIME_W-1:0] stim_ms;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("flow_sweep_pressure_setpoint regression: fail");
            $finish;
        end
    end

    // Output stall: mostly short bursts, a few long ones, and quiet stretches
    always @(negedge i_clk) begin
        stall_roll = $urandom_range(0, 99);
        if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else if (cycles[10:9] == 2'd2) begin
            i_out_stall <= 1'b0;
        end else if (stall_roll < 60) begin
            i_out_stall <= 1'b0;
            stall_hold  <= $urandom_range(0, 6);
        end else if (stall_roll < 95) begin
            i_out_stall <= 1'b1;
            stall_hold  <= $urandom_range(0, 3);
        end else begin
            i_out_stall <= 1'b1;
            stall_hold  <= $urandom_range(10, 80);
        end
    end

    always @(posedge i_clk) begin
        sweep_result_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_updates.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected update: dac %0d setpoint %0d down %0d count %0d",
                             o_dac_code, o_setpoint_out, o_going_down, o_cycle_count_out);
            end else begin
                want = expected_updates.pop_front();
                if (o_dac_code !== want.dac || o_setpoint_out !== want.setpoint ||
                    o_going_down !== want.down || o_cycle_count_out !== want.crossings) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("update mismatch (exp/act): dac %0d/%0d setpoint %0d/%0d down %0d/%0d count %0d/%0d",
                                 want.dac, o_dac_code, want.setpoint, o_setpoint_out,
                                 want.down, o_going_down, want.crossings, o_cycle_count_out);
                end
            end
        end
    end

    task automatic sweep_setpoint(input logic [TIME_W-1:0] t, input logic go_down);
        logic [63:0] elapsed;
        logic [63:0] rate;
        logic [63:0] step;
        logic [63:0] top;
        top     = 64'(FULL_SCALE) << FRAC_W;
        elapsed = (t >= m_last_ms) ? t - m_last_ms : m_last_ms - t;
        rate    = m_rate;
        if (go_down) begin
            step       = ((rate * elapsed) << DOWN_SHIFT) / STEP_DIV;
            m_setpoint = (step >= m_setpoint) ? 64'd0 : m_setpoint - step;
        end else begin
            step       = (rate * rate * elapsed) / STEP_DIV;
            m_setpoint = (step >= top - m_setpoint) ? top : m_setpoint + step;
        end
        m_last_ms = t;
    endtask

    task automatic predict_setpoint_update(input logic [CMD_W-1:0] cmd,
                                           input logic [TIME_W-1:0] t,
                                           input logic signed [DSP_W-1:0] dsp,
                                           input logic signed [FLOW_W-1:0] flow,
                                           output bit produced, output sweep_result_t res);
        int   v;
        bit   crossed;
        logic down;
        produced = 1'b0;
        crossed  = 1'b0;
        down     = 1'b0;
        res      = '0;
        case (cmd)
            CMD_DIRECT: begin
                v = dsp;
                if (v < 0) v = 0;
                if (v > FULL_SCALE) v = FULL_SCALE;
                m_setpoint = 64'(v) << FRAC_W;
                produced   = 1'b1;
            end
            CMD_START: begin
                m_armed   = 1'b1;
                m_last_ms = t;
            end
            CMD_FLOW: begin
                if (!m_armed) begin
                    // first sample only arms and sets the time base
                    m_armed   = 1'b1;
                    m_last_ms = t;
                end else if (flow < m_flow_lo) begin
                    sweep_setpoint(t, 1'b0);
                    m_down   = 1'b0;
                    produced = 1'b1;
                    crossed  = 1'b1;
                end else if (flow > m_flow_hi) begin
                    m_down = 1'b1;
                    sweep_setpoint(t, 1'b1);
                    down     = 1'b1;
                    produced = 1'b1;
                    crossed  = 1'b1;
                end else if (flow < m_flow_hi && flow > m_flow_lo) begin
                    sweep_setpoint(t, m_down);
                    down     = m_down;
                    produced = 1'b1;
                end
            end
            default: ;
        endcase
        if (produced) begin
            res.dac       = (m_setpoint * DAC_MAX) / (64'(FULL_SCALE) << FRAC_W);
            res.setpoint  = m_setpoint;
            res.down      = down;
            res.crossings = m_crossings;
        end
        if (crossed) m_crossings++;
    endtask

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (cycles[10:9] == 2'd1) return 0;
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 100);
    endfunction

    // Called at a falling edge; returns at a falling edge with valid still high
    // when no gap follows.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] t,
                             input logic [DSP_W-1:0] dsp, input logic [FLOW_W-1:0] flow,
                             input logic typed, input sweep_result_t want);
        bit            produced;
        sweep_result_t res;
        int unsigned   gap;
        i_in_valid        <= 1'b1;
        i_command         <= cmd;
        i_time_ms         <= t;
        i_direct_setpoint <= dsp;
        i_flow_sample     <= flow;
        do @(posedge i_clk); while (o_in_stall);
        predict_setpoint_update(cmd, t, dsp, flow, produced, res);
        if (produced) expected_updates.push_back(typed ? want : res);
        gap = pick_gap();
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Registers change only with the block idle: all updates in, plus a settle
    // window for items that end without an update.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_in_valid <= 1'b0;
        while (expected_updates.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_FLOW_LO: m_flow_lo = data;
            REG_FLOW_HI: m_flow_hi = data;
            REG_RATE:    m_rate    = data[RATE_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic dir_row_t item_row(logic [CMD_W-1:0] cmd, logic [TIME_W-1:0] t,
                                          logic [DSP_W-1:0] dsp, logic [FLOW_W-1:0] flow);
        item_row      = '0;
        item_row.cmd  = cmd;
        item_row.t    = t;
        item_row.dsp  = dsp;
        item_row.flow = flow;
    endfunction

    function automatic dir_row_t known_row(logic [CMD_W-1:0] cmd, logic [TIME_W-1:0] t,
                                           logic [DSP_W-1:0] dsp, logic [FLOW_W-1:0] flow,
                                           logic [DAC_W-1:0] dac, logic [SPO_W-1:0] sp,
                                           logic down, logic [CYC_W-1:0] cyc);
        known_row       = item_row(cmd, t, dsp, flow);
        known_row.typed = 1'b1;
        known_row.want  = '{dac, sp, down, cyc};
    endfunction

    function automatic dir_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        reg_row          = '0;
        reg_row.is_reg   = 1'b1;
        reg_row.reg_idx  = idx;
        reg_row.reg_data = data;
    endfunction

    function automatic logic [FLOW_W-1:0] pick_flow();
        longint      lo;
        longint      hi;
        longint      c;
        int unsigned roll;
        lo   = m_flow_lo;
        hi   = m_flow_hi;
        roll = $urandom_range(0, 99);
        if (roll < 30)      c = lo - $urandom_range(1, 1 << 18);
        else if (roll < 60) c = hi + $urandom_range(1, 1 << 18);
        else if (roll < 80) c = (hi - lo > 1) ? lo + 1 + longint'($urandom % (hi - lo - 1)) : lo;
        else if (roll < 88) c = lo;
        else if (roll < 95) c = hi;
        else                c = longint'($signed($urandom));
        if (c < -64'sd2147483648) c = -64'sd2147483648;
        if (c > 64'sd2147483647)  c = 64'sd2147483647;
        return c[FLOW_W-1:0];
    endfunction

    function automatic logic [RATE_W-1:0] pick_rate();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(1, 255);
            3:       return $urandom_range(256, 4095);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [CFG_DATA_W-1:0] lo_data;
        logic [CFG_DATA_W-1:0] hi_data;
        logic [CMD_W-1:0]      cmd;
        logic [DSP_W-1:0]      dsp;
        int unsigned           roll;
        int unsigned           sent;
        int unsigned           waited;

        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_command         = CMD_DIRECT;
        i_time_ms         = '0;
        i_direct_setpoint = '0;
        i_flow_sample     = '0;
        i_out_stall       = 1'b0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = REG_FLOW_LO;
        i_cfg_data        = '0;
        cycles            = 0;
        mismatches        = 0;
        stall_hold        = 0;

        m_setpoint  = '0;
        m_last_ms   = '0;
        m_armed     = 1'b0;
        m_down      = 1'b0;
        m_crossings = '0;
        m_flow_lo   = 32'sd65536;
        m_flow_hi   = 32'sd655360;
        m_rate      = '0;

        directed_tbl = '{
            // clamping of direct sets under reset limits and zero rate
            known_row(CMD_DIRECT, 32'd0, 16'h7fff, 32'd0, 12'd4095, 27'd67108864, 1'b0, 16'd0),
            known_row(CMD_DIRECT, 32'd0, 16'h8000, 32'd0, 12'd0, 27'd0, 1'b0, 16'd0),
            known_row(CMD_DIRECT, 32'd0, 16'd512, 32'd0, 12'd2047, 27'd33554432, 1'b0, 16'd0),
            known_row(CMD_DIRECT, 32'd0, 16'd1025, 32'd0, 12'd4095, 27'd67108864, 1'b0, 16'd0),
            known_row(CMD_DIRECT, 32'd0, 16'hffff, 32'd0, 12'd0, 27'd0, 1'b0, 16'd0),
            // unarmed flow only arms
            item_row(CMD_FLOW, 32'd100, 16'd0, 32'd0),
            known_row(CMD_FLOW, 32'd1100, 16'd0, 32'd0, 12'd0, 27'd0, 1'b0, 16'd0),
            known_row(CMD_FLOW, 32'd2100, 16'd0, 32'h7fffffff, 12'd0, 27'd0, 1'b1, 16'd1),
            // between the limits: repeat direction, no count
            known_row(CMD_FLOW, 32'd3100, 16'd0, 32'd131072, 12'd0, 27'd0, 1'b1, 16'd2),
            item_row(CMD_FLOW, 32'd4100, 16'd0, 32'd65536),
            item_row(CMD_FLOW, 32'd4100, 16'd0, 32'd655360),
            item_row(CMD_START, 32'd5000, 16'd0, 32'd0),
            item_row(CMD_UNUSED, 32'hffffffff, 16'hffff, 32'hffffffff),
            reg_row(REG_RATE, 32'h0000ffff),
            item_row(CMD_DIRECT, 32'd0, 16'd100, 32'd0),
            // largest elapsed time at full rate saturates both ways
            item_row(CMD_FLOW, 32'hffffffff, 16'd0, 32'h80000000),
            item_row(CMD_FLOW, 32'd0, 16'd0, 32'h7fffffff),
            reg_row(REG_RATE, 32'h00000100),
            item_row(CMD_FLOW, 32'd1000, 16'd0, 32'd0),
            item_row(CMD_FLOW, 32'd0, 16'd0, 32'h7fffffff),
            // crossed limits: the low test wins
            reg_row(REG_FLOW_LO, 32'h7fffffff),
            reg_row(REG_FLOW_HI, 32'h80000000),
            item_row(CMD_FLOW, 32'd2000, 16'd0, 32'd0),
            item_row(CMD_FLOW, 32'd3000, 16'd0, 32'h7fffffff),
            item_row(CMD_FLOW, 32'd4000, 16'd0, 32'h80000000)
        };

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_tbl[k]) begin
            if (directed_tbl[k].is_reg)
                write_reg(directed_tbl[k].reg_idx, directed_tbl[k].reg_data);
            else
                send_item(directed_tbl[k].cmd, directed_tbl[k].t, directed_tbl[k].dsp,
                          directed_tbl[k].flow, directed_tbl[k].typed, directed_tbl[k].want);
        end

        stim_ms = $urandom;
        for (int phase = 0; phase < N_PHASES; phase++) begin
            // each phase starts after a full drain of the pipeline
            case (phase)
                0: begin
                    lo_data = 32'h80000000;
                    hi_data = 32'h7fffffff;
                end
                1: begin
                    lo_data = 32'h7fffffff;
                    hi_data = 32'h80000000;
                end
                default: begin
                    lo_data = $urandom;
                    if ($urandom_range(0, 3) == 0) hi_data = $urandom;
                    else hi_data = lo_data + $urandom_range(0, 1 << 20);
                end
            endcase
            write_reg(REG_FLOW_LO, lo_data);
            write_reg(REG_FLOW_HI, hi_data);
            write_reg(REG_RATE, {16'($urandom), (phase == 0) ? 16'hffff : pick_rate()});

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                roll = $urandom_range(0, 99);
                if (roll < 12)      cmd = CMD_DIRECT;
                else if (roll < 20) cmd = CMD_START;
                else if (roll < 24) cmd = CMD_UNUSED;
                else                cmd = CMD_FLOW;

                roll = $urandom_range(0, 99);
                if (roll < 80)      stim_ms = stim_ms + $urandom_range(0, 3000);
                else if (roll < 90) stim_ms = stim_ms - $urandom_range(0, 3000);
                else if (roll < 95) stim_ms = $urandom;
                else                stim_ms = $urandom_range(0, 1) ? '1 : '0;

                dsp = $urandom_range(0, 1) ? 16'($urandom_range(0, 1100)) : 16'($urandom);

                send_item(cmd, stim_ms, dsp, pick_flow(), 1'b0, '0);
                if (cmd != CMD_UNUSED) sent++;
            end
        end

        i_in_valid <= 1'b0;
        waited = 0;
        while (expected_updates.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_updates.size() != 0) begin
            mismatches += expected_updates.size();
            $display("%0d expected updates never arrived", expected_updates.size());
        end

        if (mismatches == 0)
            $display("flow_sweep_pressure_setpoint regression: pass");
        else
            $display("flow_sweep_pressure_setpoint regression: fail");
        $finish;
    end

endmodule
